@@ rtl/core/bpc_pkg.sv @@
// types, codes and the per-button classification function of the button press classifier
package bpc_pkg;

  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_LONG     = 2'd2,
    ST_REPEAT   = 2'd3
  } press_state_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } press_event_e;

  // configuration register indexes
  localparam logic [1:0] CFG_REPEAT_MODE = 2'd0;
  localparam logic [1:0] CFG_CHATTER_MS  = 2'd1;
  localparam logic [1:0] CFG_LONG_MS     = 2'd2;

  localparam logic        RST_REPEAT_MODE = 1'b0;
  localparam logic [31:0] RST_CHATTER_MS  = 32'd50;
  localparam logic [31:0] RST_LONG_MS     = 32'd1000;

  typedef struct packed {
    logic        repeat_mode;
    logic [31:0] chatter_ms;
    logic [31:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    press_state_e state;
    logic [31:0]  start_ms;
  } entry_t;

  typedef struct packed {
    entry_t       nxt;
    press_event_e ev;
  } result_t;

  function automatic result_t classify(entry_t cur, logic pin_level, logic [31:0] now_ms,
                                       cfg_t cfg);
    result_t     res;
    logic [31:0] elapsed;
    logic        long_hit;
    res      = '{nxt: cur, ev: EV_NONE};
    elapsed  = now_ms - cur.start_ms;
    long_hit = elapsed > cfg.long_press_ms;
    if (!pin_level) begin
      case (cur.state)
        ST_RELEASED: begin
          res.nxt.state    = ST_PRESSED;
          res.nxt.start_ms = now_ms;
        end
        ST_PRESSED: begin
          if (long_hit) begin
            if (cfg.repeat_mode) begin
              // timer keeps running on entry to repeating
              res.nxt.state = ST_REPEAT;
            end else begin
              res.nxt.state = ST_LONG;
              res.ev        = EV_LONG;
            end
          end
        end
        ST_REPEAT: begin
          if (long_hit) begin
            res.nxt.start_ms = now_ms;
            res.ev           = EV_REPEAT;
          end
        end
        default: ;
      endcase
    end else begin
      if (cur.state == ST_PRESSED && elapsed > cfg.chatter_ms) begin
        res.ev = EV_SHORT;
      end
      res.nxt.state = ST_RELEASED;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/bpc_cfg_regs.sv @@
// configuration registers of the button press classifier
module bpc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  output bpc_pkg::cfg_t cfg_o
);
  import bpc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_mode   <= RST_REPEAT_MODE;
      cfg_q.chatter_ms    <= RST_CHATTER_MS;
      cfg_q.long_press_ms <= RST_LONG_MS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REPEAT_MODE: cfg_q.repeat_mode   <= cfg_wdata_i[0];
        CFG_CHATTER_MS:  cfg_q.chatter_ms    <= cfg_wdata_i;
        CFG_LONG_MS:     cfg_q.long_press_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/bpc_state_mem.sv @@
// per-button state memory with registered read and reset-cleared valid bits
module bpc_state_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output bpc_pkg::entry_t rd_data_o,
  output logic            rd_valid_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  bpc_pkg::entry_t wr_data_i
);
  import bpc_pkg::*;

  entry_t             mem_q [DEPTH];
  entry_t             rd_data_q;
  logic               rd_valid_q;
  logic [DEPTH-1:0]   valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign rd_valid_o = rd_valid_q;

endmodule

@@ rtl/core/button_press_classifier_top.sv @@
// top level of the button press classifier: read stage, classify and write-back stage, output register
// Classifies per-button pin samples into short press, long press and repeat tick events, one
// result per sample. A sample is read from the per-button state memory in the cycle it is
// transferred, classified in the next cycle and written back when it moves on to the output
// register, so a new sample can be taken every cycle while in_stall_o is low; a sample for the
// button the previous sample wrote gets the new state by forwarding. The output register
// holds a result while the downstream side stalls, and one more sample can wait in the
// classify stage behind it. Samples with a button index at or above NUM_BUTTONS change no
// state and give no event. Configuration writes take effect on the next cycle.
module button_press_classifier_top #(
  parameter int NUM_BUTTONS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  button_index_i,
  input  logic        pin_level_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  press_event_o
);
  import bpc_pkg::*;

  localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int IW = (AW > 3) ? AW : 3;

  cfg_t          cfg;
  logic          in_xfer;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] in_addr;
  logic          in_range;

  logic          s1_valid_q;
  logic          s1_range_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_pin_q;
  logic [31:0]   s1_now_q;
  logic          s1_move;

  entry_t        rd_data;
  logic          rd_valid;
  logic          fwd_q;
  logic          fwd_d;
  entry_t        fwd_entry_q;
  entry_t        cur_entry;
  result_t       res;
  press_event_e  ev;

  logic          out_valid_q;
  logic          out_ready;
  press_event_e  ev_q;

  bpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign idx_ext  = IW'(button_index_i);
  assign in_addr  = idx_ext[AW-1:0];
  assign in_range = {29'd0, button_index_i} < 32'(NUM_BUTTONS);

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  bpc_state_mem #(
    .DEPTH (NUM_BUTTONS),
    .AW    (AW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_xfer),
    .rd_addr_i  (in_addr),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid),
    .wr_en_i    (s1_move && s1_range_q),
    .wr_addr_i  (s1_addr_q),
    .wr_data_i  (res.nxt)
  );

  // the memory read misses a write-back to the same button in the same cycle
  assign fwd_d = s1_move && s1_range_q && (s1_addr_q == in_addr);

  always_comb begin
    if (fwd_q) begin
      cur_entry = fwd_entry_q;
    end else if (rd_valid) begin
      cur_entry = rd_data;
    end else begin
      cur_entry = '{state: ST_RELEASED, start_ms: rd_data.start_ms};
    end
    res = classify(cur_entry, s1_pin_q, s1_now_q, cfg);
    ev  = s1_range_q ? res.ev : EV_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= fwd_d;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_range_q  <= in_range;
      s1_addr_q   <= in_addr;
      s1_pin_q    <= pin_level_i;
      s1_now_q    <= now_ms_i;
      fwd_entry_q <= res.nxt;
    end
    if (s1_move) begin
      ev_q <= ev;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign press_event_o = ev_q;

endmodule

@@ dv/tb_button_press_classifier_top.sv @@
// self-checking testbench for button_press_classifier_top: directed and random pin samples
module tb_button_press_classifier_top;
  import bpc_pkg::*;

  localparam int NUM_BUTTONS = 8;
  localparam int STALL_LIMIT = 1000;

  class press_scoreboard;
    press_state_e state[NUM_BUTTONS];
    logic [31:0]  start_ms[NUM_BUTTONS];
    logic         rep_mode;
    logic [31:0]  chatter_ms;
    logic [31:0]  long_ms;
    press_event_e expected_events[$];
    int           errors;

    function new();
      foreach (state[i]) begin
        state[i]    = ST_RELEASED;
        start_ms[i] = '0;
      end
      rep_mode   = RST_REPEAT_MODE;
      chatter_ms = RST_CHATTER_MS;
      long_ms    = RST_LONG_MS;
      errors     = 0;
    endfunction

    function void set_cfg(logic mode, logic [31:0] chatter, logic [31:0] long_hold);
      rep_mode   = mode;
      chatter_ms = chatter;
      long_ms    = long_hold;
    endfunction

    // classify one accepted sample and queue its event
    function void note_sample(logic [2:0] b, logic pin, logic [31:0] now);
      logic [31:0]  held;
      press_event_e ev;
      ev   = EV_NONE;
      held = now - start_ms[b];
      if (pin) begin
        if (state[b] == ST_PRESSED && held > chatter_ms) ev = EV_SHORT;
        state[b] = ST_RELEASED;
      end else if (state[b] == ST_RELEASED) begin
        state[b]    = ST_PRESSED;
        start_ms[b] = now;
      end else if (held > long_ms) begin
        if (state[b] == ST_REPEAT) begin
          start_ms[b] = now;
          ev          = EV_REPEAT;
        end else if (state[b] == ST_PRESSED) begin
          // repeat entry keeps the old start time
          if (rep_mode) begin
            state[b] = ST_REPEAT;
          end else begin
            state[b] = ST_LONG;
            ev       = EV_LONG;
          end
        end
      end
      expected_events.push_back(ev);
    endfunction

    function void check_event(logic [1:0] got);
      press_event_e want;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: press_event %0d with nothing expected", $time, got);
        return;
      end
      want = expected_events.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: press_event expected %0d (%s) actual %0d", $time, want, want.name(), got);
      end
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_idx_i      = CFG_REPEAT_MODE;
  logic [31:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [2:0]  button_index_i = '0;
  logic        pin_level_i    = 1'b1;
  logic [31:0] now_ms_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [1:0]  press_event_o;

  press_scoreboard sb = new();

  int send_idle_pct = 35;
  int recv_idle_pct = 35;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  button_press_classifier_top #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .button_index_i(button_index_i),
    .pin_level_i   (pin_level_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .press_event_o (press_event_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_event(press_event_o);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 80;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("tb_button_press_classifier_top: done, errors");
        $finish;
      end
    end
  end

  task automatic put(input logic [2:0] b, input logic pin, input logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_index_i <= b;
    pin_level_i    <= pin;
    now_ms_i       <= now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_sample(b, pin, now);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic mode, input logic [31:0] chatter,
                           input logic [31:0] long_hold);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_REPEAT_MODE;
    cfg_wdata_i <= {31'd0, mode};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CHATTER_MS;
    cfg_wdata_i <= chatter;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LONG_MS;
    cfg_wdata_i <= long_hold;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_cfg(mode, chatter, long_hold);
    @(posedge clk_i);
  endtask

  // mostly press, hold, release runs per button with times near the thresholds
  task automatic run_random(input int count);
    logic [2:0]  b;
    logic        pin;
    logic [31:0] thr;
    logic [31:0] now;
    longint      lim;
    int          r;
    repeat (count) begin
      b = 3'($urandom_range(0, NUM_BUTTONS - 1));
      case (sb.state[b])
        ST_RELEASED: pin = ($urandom_range(0, 99) >= 75);
        ST_PRESSED:  pin = ($urandom_range(0, 99) >= 65);
        default:     pin = ($urandom_range(0, 99) >= 70);
      endcase
      if (sb.state[b] == ST_RELEASED) begin
        now = $urandom();
      end else begin
        thr = (pin && sb.state[b] == ST_PRESSED) ? sb.chatter_ms : sb.long_ms;
        r   = $urandom_range(0, 99);
        if (r < 30) begin
          now = sb.start_ms[b] + thr - 32'd2 + 32'($urandom_range(0, 4));
        end else if (r < 75) begin
          lim = longint'(thr) + thr / 2 + 3;
          if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
          now = sb.start_ms[b] + 32'($urandom_range(0, 32'(lim)));
        end else begin
          now = sb.start_ms[b] + $urandom();
        end
      end
      put(b, pin, now);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: short press at and past the chatter time
    put(3'd0, 1'b0, 32'd0);
    put(3'd0, 1'b1, 32'd50);
    put(3'd0, 1'b0, 32'd100);
    put(3'd0, 1'b1, 32'd151);
    // long press across the wrap of the millisecond counter, then held and released
    put(3'd1, 1'b0, 32'hFFFF_FFF0);
    put(3'd1, 1'b0, 32'hFFFF_FFF0 + 32'd1000);
    put(3'd1, 1'b0, 32'hFFFF_FFF0 + 32'd1001);
    put(3'd1, 1'b0, 32'h0000_5000);
    put(3'd1, 1'b1, 32'h0000_6000);
    put(3'd2, 1'b0, 32'd200);
    put(3'd2, 1'b0, 32'd1201);
    put(3'd7, 1'b0, 32'hFFFF_FFFF);
    put(3'd6, 1'b1, 32'hAAAA_5555);
    put(3'd5, 1'b1, 32'h5555_AAAA);
    // switch to repeat while one button is long-held and another still pressed
    configure(1'b1, RST_CHATTER_MS, RST_LONG_MS);
    put(3'd2, 1'b0, 32'd9000);
    put(3'd7, 1'b0, 32'd1000);
    put(3'd7, 1'b0, 32'd1000);
    put(3'd7, 1'b0, 32'd1001);
    put(3'd7, 1'b0, 32'd2002);
    put(3'd7, 1'b1, 32'd3000);
    put(3'd2, 1'b1, 32'd9100);

    configure(1'b0, 32'd50, 32'd1000);
    run_random(175);

    // a stretch with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1'b1, 32'd20, 32'd300);
    run_random(175);
    send_idle_pct = 35;
    recv_idle_pct = 35;

    configure(1'b1, 32'd0, 32'd0);
    run_random(175);

    // receiver holds off so the block fills and stalls its input
    configure(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    run_random(175);

    configure(1'b1, 32'($urandom_range(0, 200)), 32'($urandom_range(1, 3000)));
    run_random(175);

    configure(1'b0, 32'd0, 32'd5);
    run_random(175);

    configure(1'b1, 32'd100, 32'hFFFF_FFFF);
    run_random(175);

    drain();
    if (sb.errors == 0) begin
      $display("tb_button_press_classifier_top: done, clean");
    end else begin
      $display("tb_button_press_classifier_top: done, errors");
    end
    $finish;
  end

endmodule

@@ button_press_classifier_top.f @@
rtl/core/bpc_pkg.sv
rtl/core/bpc_cfg_regs.sv
rtl/core/bpc_state_mem.sv
rtl/core/button_press_classifier_top.sv
dv/tb_button_press_classifier_top.sv
